@@ hdl/ncodc_pkg.sv @@
// Shared types, constants and the quarter-wave sine table for the NCO downconverter.
package ncodc_pkg;

    // Phase accumulator and table addressing
    localparam int TBL_BITS        = 8;
    localparam int QTR_BITS        = TBL_BITS - 2;
    localparam int QTR_DEPTH       = 1 << QTR_BITS;
    localparam int PHASE_FRAC_BITS = 12;
    localparam int ACC_BITS        = TBL_BITS + PHASE_FRAC_BITS;

    // Trig values are Q1.14; the magnitude needs one extra integer bit.
    localparam int TRIG_FRAC_BITS  = 14;
    localparam int MAG_BITS        = TRIG_FRAC_BITS + 1;
    localparam int TRIG_BITS       = MAG_BITS + 1;

    // Sample and result widths
    localparam int SAMPLE_BITS     = 8;
    localparam int NIB_BITS        = 4;
    localparam int OUT_BITS        = 20;
    localparam int PROD_BITS       = NIB_BITS + 1 + TRIG_BITS;
    localparam int SUM_BITS        = PROD_BITS + 1;

    // Frame bookkeeping
    localparam int CNT_BITS        = 17;
    localparam int MAX_FRAME       = 65536;

    // Configuration port
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 20;
    localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_INC    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_VALID_COUNT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_LENGTH = 2'd2;

    localparam logic [ACC_BITS-1:0] RST_PHASE_INC    = '0;
    localparam logic [CNT_BITS-1:0] RST_VALID_COUNT  = 17'd4096;
    localparam logic [CNT_BITS-1:0] RST_FRAME_LENGTH = 17'd4096;

    // First quadrant of sin(2*pi*k/256) in Q1.14, rounded to nearest, k = 0..64.
    localparam logic [MAG_BITS-1:0] SINE_QTR [0:QTR_DEPTH] = '{
        15'd0,     15'd402,   15'd804,   15'd1205,  15'd1606,  15'd2006,  15'd2404,
        15'd2801,  15'd3196,  15'd3590,  15'd3981,  15'd4370,  15'd4756,  15'd5139,
        15'd5520,  15'd5897,  15'd6270,  15'd6639,  15'd7005,  15'd7366,  15'd7723,
        15'd8076,  15'd8423,  15'd8765,  15'd9102,  15'd9434,  15'd9760,  15'd10080,
        15'd10394, 15'd10702, 15'd11003, 15'd11297, 15'd11585, 15'd11866, 15'd12140,
        15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395, 15'd13623, 15'd13842,
        15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811, 15'd14978, 15'd15137,
        15'd15286, 15'd15426, 15'd15557, 15'd15679, 15'd15791, 15'd15893, 15'd15986,
        15'd16069, 15'd16143, 15'd16207, 15'd16261, 15'd16305, 15'd16340, 15'd16364,
        15'd16379, 15'd16384
    };

    // Configuration registers
    typedef struct packed {
        logic [ACC_BITS-1:0] phase_inc;
        logic [CNT_BITS-1:0] valid_count;
        logic [CNT_BITS-1:0] frame_length;
    } t_cfg;

    // Per-slot control produced by the oscillator
    typedef struct packed {
        logic [TBL_BITS-1:0] idx;
        logic                pad;
        logic                last;
    } t_slot;

    // Full-wave sine from the quarter table: mirror in odd quadrants, negate in the upper half.
    function automatic logic signed [TRIG_BITS-1:0] trig_lookup(input logic [TBL_BITS-1:0] idx);
        logic [QTR_BITS-1:0] r;
        logic [QTR_BITS:0]   addr;
        logic [MAG_BITS-1:0] mag;
        r    = idx[QTR_BITS-1:0];
        addr = idx[QTR_BITS] ? ((QTR_BITS+1)'(QTR_DEPTH) - {1'b0, r}) : {1'b0, r};
        mag  = SINE_QTR[addr];
        if (idx[TBL_BITS-1]) begin
            return -$signed({1'b0, mag});
        end
        return $signed({1'b0, mag});
    endfunction

endpackage

@@ hdl/ncodc_nco.sv @@
// Phase accumulator and slot counter that produce the table index and frame flags per slot.
module ncodc_nco (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ncodc_pkg::t_cfg       i_cfg,
    input  logic                  i_advance,
    output ncodc_pkg::t_slot      o_slot
);

    logic [ncodc_pkg::ACC_BITS-1:0] r_phase;
    logic [ncodc_pkg::CNT_BITS-1:0] r_slot;
    logic [ncodc_pkg::ACC_BITS-1:0] n_phase;
    logic [ncodc_pkg::CNT_BITS-1:0] n_slot;
    logic [ncodc_pkg::CNT_BITS-1:0] flen_eff;
    logic [ncodc_pkg::CNT_BITS-1:0] vlen_eff;
    logic [ncodc_pkg::CNT_BITS:0]   slot_inc;
    logic                           pad;
    logic                           last;

    // Frame length is at least one and at most the largest frame; valid count is clipped to it.
    always_comb begin
        if (i_cfg.frame_length == '0) begin
            flen_eff = ncodc_pkg::CNT_BITS'(1);
        end else if (i_cfg.frame_length > ncodc_pkg::CNT_BITS'(ncodc_pkg::MAX_FRAME)) begin
            flen_eff = ncodc_pkg::CNT_BITS'(ncodc_pkg::MAX_FRAME);
        end else begin
            flen_eff = i_cfg.frame_length;
        end
        vlen_eff = (i_cfg.valid_count > flen_eff) ? flen_eff : i_cfg.valid_count;
    end

    // Slot classification for the current slot.
    assign slot_inc = {1'b0, r_slot} + (ncodc_pkg::CNT_BITS+1)'(1);
    assign pad      = (r_slot >= vlen_eff);
    assign last     = (slot_inc >= {1'b0, flen_eff});

    // Next state: restart at phase zero after the last slot of a frame.
    always_comb begin
        if (last) begin
            n_slot  = '0;
            n_phase = '0;
        end else begin
            n_slot  = slot_inc[ncodc_pkg::CNT_BITS-1:0];
            n_phase = r_phase + i_cfg.phase_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_phase <= '0;
        end else if (i_advance) begin
            r_slot  <= n_slot;
            r_phase <= n_phase;
        end
    end

    assign o_slot.idx  = r_phase[ncodc_pkg::ACC_BITS-1:ncodc_pkg::PHASE_FRAC_BITS];
    assign o_slot.pad  = pad;
    assign o_slot.last = last;

endmodule

@@ hdl/ncodc_mixer.sv @@
// Table lookup and complex multiply of one sample, with the result register.
module ncodc_mixer (
    input  logic                                      i_clk,
    input  logic                                      i_load,
    input  logic [ncodc_pkg::SAMPLE_BITS-1:0]         i_raw,
    input  ncodc_pkg::t_slot                          i_slot,
    output logic signed [ncodc_pkg::OUT_BITS-1:0]     o_re,
    output logic signed [ncodc_pkg::OUT_BITS-1:0]     o_im,
    output logic                                      o_last
);

    logic signed [ncodc_pkg::TRIG_BITS-1:0]  sin_v;
    logic signed [ncodc_pkg::TRIG_BITS-1:0]  cos_v;
    logic signed [ncodc_pkg::NIB_BITS:0]     iv;
    logic signed [ncodc_pkg::NIB_BITS:0]     qv;
    logic signed [ncodc_pkg::PROD_BITS-1:0]  p_ic;
    logic signed [ncodc_pkg::PROD_BITS-1:0]  p_qs;
    logic signed [ncodc_pkg::PROD_BITS-1:0]  p_is;
    logic signed [ncodc_pkg::PROD_BITS-1:0]  p_qc;
    logic signed [ncodc_pkg::SUM_BITS-1:0]   re_full;
    logic signed [ncodc_pkg::SUM_BITS-1:0]   im_full;
    logic signed [ncodc_pkg::OUT_BITS-1:0]   n_re;
    logic signed [ncodc_pkg::OUT_BITS-1:0]   n_im;
    logic signed [ncodc_pkg::OUT_BITS-1:0]   r_re;
    logic signed [ncodc_pkg::OUT_BITS-1:0]   r_im;
    logic                                    r_last;

    // Cosine is the sine a quarter turn ahead.
    assign sin_v = ncodc_pkg::trig_lookup(i_slot.idx);
    assign cos_v = ncodc_pkg::trig_lookup(i_slot.idx +
                   ncodc_pkg::TBL_BITS'(ncodc_pkg::QTR_DEPTH));

    // Unpack the nibbles as non-negative signed operands.
    assign iv = $signed({1'b0, i_raw[ncodc_pkg::NIB_BITS-1:0]});
    assign qv = $signed({1'b0, i_raw[ncodc_pkg::SAMPLE_BITS-1:ncodc_pkg::NIB_BITS]});

    // Four small products and the complex sum.
    assign p_ic    = ncodc_pkg::PROD_BITS'(iv) * ncodc_pkg::PROD_BITS'(cos_v);
    assign p_qs    = ncodc_pkg::PROD_BITS'(qv) * ncodc_pkg::PROD_BITS'(sin_v);
    assign p_is    = ncodc_pkg::PROD_BITS'(iv) * ncodc_pkg::PROD_BITS'(sin_v);
    assign p_qc    = ncodc_pkg::PROD_BITS'(qv) * ncodc_pkg::PROD_BITS'(cos_v);
    assign re_full = ncodc_pkg::SUM_BITS'(p_ic) - ncodc_pkg::SUM_BITS'(p_qs);
    assign im_full = ncodc_pkg::SUM_BITS'(p_is) + ncodc_pkg::SUM_BITS'(p_qc);

    // Padding slots give zero; otherwise keep the low result bits.
    assign n_re = i_slot.pad ? '0 : $signed(re_full[ncodc_pkg::OUT_BITS-1:0]);
    assign n_im = i_slot.pad ? '0 : $signed(im_full[ncodc_pkg::OUT_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_re   <= n_re;
            r_im   <= n_im;
            r_last <= i_slot.last;
        end
    end

    assign o_re   = r_re;
    assign o_im   = r_im;
    assign o_last = r_last;

endmodule

@@ hdl/nco_lut_downconverter_core.sv @@
// Top level of the NCO downconverter: configuration registers, handshake and the two stages.
//
// Usage:
//   Write the phase increment (index 0), valid_count (index 1) and frame_length (index 2)
//   through i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle. Writes to other
//   indexes are ignored.
//   Input transfer: i_in_valid high and o_in_stall low at a rising edge; each transfer
//   carries one packed byte (I in the low nibble, Q in the high nibble).
//   Output transfer: o_out_valid high and i_out_stall low; each input gives one result
//   (mixed_re, mixed_im, frame_end).
//   The input register takes the sample and its slot control, then table lookup and
//   multiply fill the result register. One item per cycle is sustained while the
//   receiver does not stall; the two registers let a new transfer in while a result waits.
//   When the receiver stalls, the result holds; one more item waits in the input
//   register, after which o_in_stall rises.
//   Reset (synchronous, active low) empties both stages, zeros the phase and slot
//   counter, and loads the register defaults 0, 4096 and 4096.
module nco_lut_downconverter_core (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [ncodc_pkg::CFG_IDX_BITS-1:0]        i_cfg_idx,
    input  logic [ncodc_pkg::CFG_DATA_BITS-1:0]       i_cfg_data,
    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  logic [ncodc_pkg::SAMPLE_BITS-1:0]         i_raw_sample,
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output logic signed [ncodc_pkg::OUT_BITS-1:0]     o_mixed_re,
    output logic signed [ncodc_pkg::OUT_BITS-1:0]     o_mixed_im,
    output logic                                      o_frame_end
);

    ncodc_pkg::t_cfg                          r_cfg;
    ncodc_pkg::t_slot                         slot_info;
    ncodc_pkg::t_slot                         r_a_slot;
    logic [ncodc_pkg::SAMPLE_BITS-1:0]        r_a_raw;
    logic                                     r_a_valid;
    logic                                     r_b_valid;
    logic                                     n_a_valid;
    logic                                     n_b_valid;
    logic                                     b_take;
    logic                                     a_move;
    logic                                     in_xfer;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_inc    <= ncodc_pkg::RST_PHASE_INC;
            r_cfg.valid_count  <= ncodc_pkg::RST_VALID_COUNT;
            r_cfg.frame_length <= ncodc_pkg::RST_FRAME_LENGTH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ncodc_pkg::REG_PHASE_INC: begin
                    r_cfg.phase_inc <= i_cfg_data[ncodc_pkg::ACC_BITS-1:0];
                end
                ncodc_pkg::REG_VALID_COUNT: begin
                    r_cfg.valid_count <= i_cfg_data[ncodc_pkg::CNT_BITS-1:0];
                end
                ncodc_pkg::REG_FRAME_LENGTH: begin
                    r_cfg.frame_length <= i_cfg_data[ncodc_pkg::CNT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Handshake: the result register frees when empty or when its transfer completes.
    assign b_take     = !r_b_valid || !i_out_stall;
    assign a_move     = r_a_valid && b_take;
    assign o_in_stall = r_a_valid && !b_take;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_comb begin
        n_a_valid = r_a_valid;
        if (in_xfer) begin
            n_a_valid = 1'b1;
        end else if (a_move) begin
            n_a_valid = 1'b0;
        end
        n_b_valid = r_b_valid;
        if (a_move) begin
            n_b_valid = 1'b1;
        end else if (b_take) begin
            n_b_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
        end
    end

    // Oscillator steps once per accepted sample.
    ncodc_nco u_nco (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_advance (in_xfer),
        .o_slot    (slot_info)
    );

    // Input register: the sample and its slot control.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a_raw  <= i_raw_sample;
            r_a_slot <= slot_info;
        end
    end

    // Mixer with the result register.
    ncodc_mixer u_mixer (
        .i_clk  (i_clk),
        .i_load (a_move),
        .i_raw  (r_a_raw),
        .i_slot (r_a_slot),
        .o_re   (o_mixed_re),
        .o_im   (o_mixed_im),
        .o_last (o_frame_end)
    );

    assign o_out_valid = r_b_valid;

endmodule
